[sv/sync_word_bit_deframer_defines.svh]
// ----------------------------------------------------------------------------
// sync word deframer assertion macros
// shared concurrent assertion forms, clocked and reset-gated in one place
// ----------------------------------------------------------------------------
`ifndef SYNC_WORD_BIT_DEFRAMER_DEFINES_SVH
`define SYNC_WORD_BIT_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define SWBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/swbd_pkg.sv]
// ----------------------------------------------------------------------------
// swbd_pkg
// widths, field sizes and register codes of the sync word deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swbd_pkg;

    // frame layout
    localparam int SYNC_BITS    = 16;
    localparam int MEASURE_BITS = 12;
    localparam int TICK_BITS    = 16;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int PATTERN_W = 16;
    localparam int INDEX_W   = 12;
    localparam int MEASURE_W = 12;
    localparam int TICK_W    = 16;
    localparam int SLOT_W    = INDEX_W + 1;

    // internal widths derived from the layout
    localparam int SYNC_EXT_W = (SYNC_BITS > PATTERN_W) ? SYNC_BITS : PATTERN_W;
    localparam int MEAS_EXT_W = (MEASURE_BITS > MEASURE_W) ? MEASURE_BITS : MEASURE_W;
    localparam int TICK_EXT_W = (TICK_BITS > TICK_W) ? TICK_BITS : TICK_W;
    localparam int FIELD_MAX  = (MEASURE_BITS > TICK_BITS) ? MEASURE_BITS : TICK_BITS;
    localparam int FILL_W     = $clog2(SYNC_BITS + 1);
    localparam int CNT_W      = $clog2(FIELD_MAX + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX   = 2'd2;

    localparam logic [INDEX_W-1:0] LAST_INDEX_RST = '1;
    localparam logic [SLOT_W-1:0]  SLOT_LIMIT     = SLOT_W'(1 << INDEX_W);

endpackage

[sv/swbd_in_if.sv]
// ----------------------------------------------------------------------------
// swbd_in_if
// byte stream channel into the deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swbd_in_if;
    import swbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[sv/swbd_out_if.sv]
// ----------------------------------------------------------------------------
// swbd_out_if
// record channel out of the deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swbd_out_if;
    import swbd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MEASURE_W-1:0] measure_value;
    logic [TICK_W-1:0]    tick_value;
    logic [INDEX_W-1:0]   slot_index;

    modport source (
        output valid, output measure_value, output tick_value, output slot_index,
        input ready
    );
    modport sink (
        input valid, input measure_value, input tick_value, input slot_index,
        output ready
    );
endinterface

[sv/sync_word_bit_deframer.sv]
// ----------------------------------------------------------------------------
// sync_word_bit_deframer
// bit-granular sync word search and record extraction over a byte stream
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and gives at most one record per byte.
// Each byte is held in an input register; once it moves on, all eight of its
// bits, least significant first, step through the search and field capture
// logic in one pass, and a completed record lands in the output register.
// That eight bit chain is the longest path. A byte is taken while a record
// still waits in the output register; the input side stalls only when both
// registers are full. A byte flagged last_byte ends the buffer: a partial
// record is dropped and the slot counter restarts at first_index. The user
// must write configuration only while no transaction is in flight; the
// block itself does not enforce it.
`timescale 1ns / 1ps
`include "sync_word_bit_deframer_defines.svh"

module sync_word_bit_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    swbd_in_if.sink                       i_byte,
    swbd_out_if.source                    o_rec
);
    import swbd_pkg::*;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_MEASURE,
        PH_TICK
    } t_phase;

    // configuration registers
    logic [PATTERN_W-1:0] r_sync_pattern;
    logic [INDEX_W-1:0]   r_first_index;
    logic [INDEX_W-1:0]   r_last_index;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_last;

    // search and capture state
    logic [SYNC_BITS-1:0]    r_window;
    logic [FILL_W-1:0]       r_fill;
    t_phase                  r_phase;
    logic [CNT_W-1:0]        r_cnt;
    logic [MEASURE_BITS-1:0] r_meas;
    logic [TICK_BITS-1:0]    r_tick;
    logic [SLOT_W-1:0]       r_slot;

    // output register
    logic                 r_out_valid;
    logic [MEASURE_W-1:0] r_out_meas;
    logic [TICK_W-1:0]    r_out_tick;
    logic [INDEX_W-1:0]   r_out_slot;

    // next state of the single pass
    logic [SYNC_BITS-1:0]    n_window;
    logic [FILL_W-1:0]       n_fill;
    t_phase                  n_phase;
    logic [CNT_W-1:0]        n_cnt;
    logic [MEASURE_BITS-1:0] n_meas;
    logic [TICK_BITS-1:0]    n_tick;
    logic [SLOT_W-1:0]       n_slot;

    logic                 rec_hit;
    logic [MEASURE_W-1:0] rec_meas;
    logic [TICK_W-1:0]    rec_tick;
    logic [INDEX_W-1:0]   rec_slot;

    logic in_xfer;
    logic advance;

    logic [SYNC_EXT_W-1:0] pattern_ext;
    logic [SYNC_BITS-1:0]  pattern_cmp;

    // upper bits of the sync word beyond the register are zero
    assign pattern_ext = SYNC_EXT_W'(r_sync_pattern);
    assign pattern_cmp = pattern_ext[SYNC_BITS-1:0];

    // byte moves from the input register through the pass when the
    // output register is free or being emptied this cycle
    assign advance = r_in_valid && (!r_out_valid || o_rec.ready);
    assign i_byte.ready = !r_in_valid || advance;
    assign in_xfer = i_byte.valid && i_byte.ready;

    assign o_rec.valid         = r_out_valid;
    assign o_rec.measure_value = r_out_meas;
    assign o_rec.tick_value    = r_out_tick;
    assign o_rec.slot_index    = r_out_slot;

    // eight bit steps of one byte
    always_comb begin
        logic                  bit_v;
        logic [MEAS_EXT_W-1:0] meas_ext;
        logic [TICK_EXT_W-1:0] tick_ext;

        n_window = r_window;
        n_fill   = r_fill;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_meas   = r_meas;
        n_tick   = r_tick;
        n_slot   = r_slot;
        rec_hit  = 1'b0;
        meas_ext = '0;
        tick_ext = '0;
        rec_meas = '0;
        rec_tick = '0;
        rec_slot = '0;

        for (int b = 0; b < BYTE_W; b++) begin
            bit_v = r_in_data[b];
            // slot counter only grows inside a byte, so once past the last
            // slot the remaining bits are ignored
            if (n_slot <= {1'b0, r_last_index}) begin
                case (n_phase)
                    PH_MEASURE: begin
                        // shift in from the top: after the full field the
                        // first bit sits at bit 0
                        n_meas = (n_meas >> 1)
                               | (MEASURE_BITS'(bit_v) << (MEASURE_BITS - 1));
                        n_cnt = n_cnt + 1'b1;
                        if (n_cnt >= CNT_W'(MEASURE_BITS)) begin
                            n_phase = PH_TICK;
                            n_cnt   = '0;
                        end
                    end
                    PH_TICK: begin
                        n_tick = (n_tick >> 1)
                               | (TICK_BITS'(bit_v) << (TICK_BITS - 1));
                        n_cnt = n_cnt + 1'b1;
                        if (n_cnt >= CNT_W'(TICK_BITS)) begin
                            meas_ext = MEAS_EXT_W'(n_meas);
                            tick_ext = TICK_EXT_W'(n_tick);
                            rec_hit  = 1'b1;
                            rec_meas = meas_ext[MEASURE_W-1:0];
                            rec_tick = tick_ext[TICK_W-1:0];
                            rec_slot = n_slot[INDEX_W-1:0];
                            if (n_slot < SLOT_LIMIT) begin
                                n_slot = n_slot + 1'b1;
                            end
                            n_window = '0;
                            n_fill   = '0;
                            n_phase  = PH_SEARCH;
                            n_cnt    = '0;
                            n_meas   = '0;
                            n_tick   = '0;
                        end
                    end
                    default: begin
                        n_window = (n_window >> 1)
                                 | (SYNC_BITS'(bit_v) << (SYNC_BITS - 1));
                        if (n_fill < FILL_W'(SYNC_BITS)) begin
                            n_fill = n_fill + 1'b1;
                        end
                        if (n_fill >= FILL_W'(SYNC_BITS) && n_window == pattern_cmp) begin
                            n_phase = PH_MEASURE;
                            n_cnt   = '0;
                            n_meas  = '0;
                            n_tick  = '0;
                        end
                    end
                endcase
            end
        end

        // end of buffer drops any partial record
        if (r_in_last) begin
            n_window = '0;
            n_fill   = '0;
            n_phase  = PH_SEARCH;
            n_cnt    = '0;
            n_meas   = '0;
            n_tick   = '0;
            n_slot   = {1'b0, r_first_index};
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_data <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    // search state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern <= '0;
            r_first_index  <= '0;
            r_last_index   <= LAST_INDEX_RST;
            r_window       <= '0;
            r_fill         <= '0;
            r_phase        <= PH_SEARCH;
            r_cnt          <= '0;
            r_meas         <= '0;
            r_tick         <= '0;
            r_slot         <= '0;
        end else begin
            if (advance) begin
                r_window <= n_window;
                r_fill   <= n_fill;
                r_phase  <= n_phase;
                r_cnt    <= n_cnt;
                r_meas   <= n_meas;
                r_tick   <= n_tick;
                r_slot   <= n_slot;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_PATTERN: r_sync_pattern <= i_cfg_data[PATTERN_W-1:0];
                    CFG_FIRST_INDEX: begin
                        r_first_index <= i_cfg_data[INDEX_W-1:0];
                        r_slot        <= {1'b0, i_cfg_data[INDEX_W-1:0]};
                    end
                    CFG_LAST_INDEX:   r_last_index <= i_cfg_data[INDEX_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= rec_hit;
        end else if (o_rec.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && rec_hit) begin
            r_out_meas <= rec_meas;
            r_out_tick <= rec_tick;
            r_out_slot <= rec_slot;
        end
    end

    // a stalled input side means a byte is parked in the input register
    `SWBD_ASSERT_NOW(a_stall_has_byte, i_clk, i_rst_n, !i_byte.ready, r_in_valid,
        "input stalled with empty input register")

    // field capture only runs after a full sync window
    `SWBD_ASSERT_NOW(a_capture_full_window, i_clk, i_rst_n, r_phase != PH_SEARCH,
        r_fill == FILL_W'(SYNC_BITS), "field capture without a full sync window")

    // bit counter is idle while searching
    `SWBD_ASSERT_NOW(a_search_cnt_zero, i_clk, i_rst_n, r_phase == PH_SEARCH, r_cnt == '0,
        "field counter busy during search")

    // slot counter saturates one past the top slot
    `SWBD_ASSERT_NOW(a_slot_bound, i_clk, i_rst_n, 1'b1, r_slot <= SLOT_LIMIT,
        "slot counter beyond its limit")

    // a record shown but not taken is still shown next cycle
    `SWBD_ASSERT_NEXT(a_rec_held, i_clk, i_rst_n, r_out_valid && !o_rec.ready, r_out_valid,
        "pending record lost")

endmodule
